[rtl/core/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// Window geometry, sample type, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

	localparam int WIN_MAX  = 64;
	localparam int IDX_W    = $clog2(WIN_MAX);
	localparam int CNT_W    = $clog2(WIN_MAX + 1);
	localparam int SAMPLE_W = 32;
	localparam int WS_W     = 7;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

	// register index 0 is window_size
	localparam logic ADDR_IDX_WS = 1'b0;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_EMIT,
		ST_REMOVE
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic insert;
		logic emit;
		logic remove;
	} cmd_t;

	typedef struct packed {
		logic fills;
	} status_t;

endpackage

`default_nettype wire

[rtl/core/swm_if.sv]
// ----------------------------------------------------------------------------
// swm_if: valid/ready channels of the sliding window median filter
// One channel for incoming samples, one for outgoing medians.
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_sample_if;
	logic             valid;
	logic             ready;
	swm_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if;
	logic             valid;
	logic             ready;
	swm_pkg::sample_t median;

	modport source (output valid, output median, input ready);
	modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

[rtl/core/sliding_window_median_top.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_top: streaming lower-median filter
// Keeps the most recent window_size samples in arrival order and sorted, and
// emits the lower median of every full window.
// ----------------------------------------------------------------------------
//
//  channel   | role   | payload           | handshake
//  ----------+--------+-------------------+----------------------
//  samples   | sink   | sample  (s32)     | valid/ready
//  medians   | source | median  (s32)     | valid/ready
//  apb       | slave  | window_size (u7)  | psel/penable/pwrite
//
//  A sample steps through accept and insert while the window is still filling,
//  and through accept, insert, emit and evict once it is full, set by the
//  controller's sequence over the single sorted cell row; a held median stalls
//  the emit step. Reset empties the window and sets window_size to 3.
//  The output register holds a median while the next sample is accepted.
//
`default_nettype none

module sliding_window_median_top (
	input  wire                          clk,
	input  wire                          arst_n,
	swm_sample_if.sink                   samples,
	swm_median_if.source                 medians,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [swm_pkg::APB_AW-1:0]    paddr,
	input  wire [swm_pkg::APB_DW-1:0]    pwdata,
	output logic [swm_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	logic [swm_pkg::WS_W-1:0] window_size_q;
	logic                     ws_sel;
	logic                     cfg_write;
	swm_pkg::cmd_t            cmd;
	swm_pkg::status_t         status;

	// register index comes from the word address
	assign ws_sel    = (paddr[2] == swm_pkg::ADDR_IDX_WS);
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && ws_sel;
	assign prdata    = ws_sel ? swm_pkg::APB_DW'(window_size_q) : '0;

	// hold window_size; a write to it also empties the window (via the controller)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swm_pkg::WS_RESET;
		end else if (cfg_write) begin
			window_size_q <= pwdata[swm_pkg::WS_W-1:0];
		end
	end

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (medians.valid),
		.out_ready (medians.ready),
		.cfg_write (cfg_write),
		.status    (status),
		.cmd       (cmd)
	);

	swm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.window_size (window_size_q),
		.sample      (samples.sample),
		.median      (medians.median),
		.status      (status)
	);

`ifndef NO_ASSERTIONS
	// an eviction always directly follows the emit that read the oldest sample
	a_remove_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.remove |-> $past(cmd.emit))
		else $error("eviction without preceding emit");

	// insert only in the cycle after a transaction on the sample channel
	a_insert_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> $past(samples.valid && samples.ready))
		else $error("insert without accepted sample");

	// sequencing steps never overlap
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.insert, cmd.emit, cmd.remove}))
		else $error("overlapping datapath commands");

	// a new median is loaded only when the output register is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!medians.valid || medians.ready))
		else $error("median overwritten while held");
`endif

endmodule

`default_nettype wire

[rtl/core/swm_ctrl.sv]
// ----------------------------------------------------------------------------
// swm_ctrl: sequencing of one sample through the datapath
// Accept, insert, then (window full) emit and evict; owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  wire               cfg_write,
	input  swm_pkg::status_t  status,
	output swm_pkg::cmd_t     cmd
);

	swm_pkg::state_t state_q;
	swm_pkg::state_t state_next;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			swm_pkg::ST_IDLE: begin
				if (in_valid) state_next = swm_pkg::ST_INSERT;
			end
			swm_pkg::ST_INSERT: begin
				state_next = status.fills ? swm_pkg::ST_EMIT : swm_pkg::ST_IDLE;
			end
			swm_pkg::ST_EMIT: begin
				if (out_free) state_next = swm_pkg::ST_REMOVE;
			end
			swm_pkg::ST_REMOVE: begin
				state_next = swm_pkg::ST_IDLE;
			end
			default: begin
				state_next = swm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		cmd.clear = cfg_write;
		case (state_q)
			swm_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			swm_pkg::ST_INSERT: begin
				cmd.insert = 1'b1;
			end
			swm_pkg::ST_EMIT: begin
				cmd.emit = out_free;
			end
			swm_pkg::ST_REMOVE: begin
				cmd.remove = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/swm_dp.sv]
// ----------------------------------------------------------------------------
// swm_dp: arrival ring, sorted cell row and output register
// Each sorted cell compares against the new or leaving sample and shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_dp (
	input  wire                             clk,
	input  wire                             arst_n,
	input  swm_pkg::cmd_t                   cmd,
	input  wire [swm_pkg::WS_W-1:0]         window_size,
	input  swm_pkg::sample_t                sample,
	output swm_pkg::sample_t                median,
	output swm_pkg::status_t                status
);

	localparam int WIN = swm_pkg::WIN_MAX;

	swm_pkg::sample_t ring_mem [WIN];
	swm_pkg::sample_t sorted_q [WIN];
	swm_pkg::sample_t sample_q;
	swm_pkg::sample_t ring_rd_q;
	swm_pkg::sample_t median_q;

	logic [swm_pkg::IDX_W-1:0] ptr_q;
	logic [swm_pkg::CNT_W-1:0] fill_q;
	logic [swm_pkg::CNT_W-1:0] win;
	logic [swm_pkg::IDX_W-1:0] mid;
	logic [swm_pkg::IDX_W-1:0] slot;
	logic [swm_pkg::IDX_W-1:0] ptr_inc;
	logic [swm_pkg::CNT_W:0]   slot_sum;
	logic [WIN-1:0]            le;
	logic [WIN-1:0]            ge;

	// clamp window: zero acts as one, oversize saturates
	always_comb begin
		if (window_size == '0) begin
			win = swm_pkg::CNT_W'(1);
		end else if (int'(window_size) > WIN) begin
			win = swm_pkg::CNT_W'(WIN);
		end else begin
			win = swm_pkg::CNT_W'(window_size);
		end
	end

	assign mid          = swm_pkg::IDX_W'((win - 1'b1) >> 1);
	assign slot_sum     = (swm_pkg::CNT_W+1)'(ptr_q) + (swm_pkg::CNT_W+1)'(fill_q);
	assign slot         = (slot_sum >= (swm_pkg::CNT_W+1)'(WIN))
		? swm_pkg::IDX_W'(slot_sum - (swm_pkg::CNT_W+1)'(WIN))
		: swm_pkg::IDX_W'(slot_sum);
	assign ptr_inc      = (ptr_q == swm_pkg::IDX_W'(WIN - 1)) ? '0 : ptr_q + 1'b1;
	assign status.fills = (swm_pkg::CNT_W'(fill_q + 1'b1) == win);
	assign median       = median_q;

	// cell row: insert keeps cells at or below the new value, shifts the rest up;
	// remove shifts down from the first cell not below the leaving value
	genvar i;
	generate
		for (i = 0; i < WIN; i++) begin : g_cell
			assign le[i] = (swm_pkg::CNT_W'(i) < fill_q) && (sorted_q[i] <= sample_q);
			assign ge[i] = (sorted_q[i] >= ring_rd_q);

			always_ff @(posedge clk) begin
				if (cmd.insert && !le[i]) begin
					if (i == 0) begin
						sorted_q[i] <= sample_q;
					end else begin
						sorted_q[i] <= le[(i == 0) ? 0 : i-1] ? sample_q
							: sorted_q[(i == 0) ? 0 : i-1];
					end
				end else if (cmd.remove && ge[i] && (i < WIN - 1)) begin
					sorted_q[i] <= sorted_q[(i < WIN - 1) ? i+1 : i];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			ring_mem[slot] <= sample_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
		end
		if (cmd.emit) begin
			ring_rd_q <= ring_mem[ptr_q];
			median_q  <= sorted_q[mid];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (cmd.clear) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (cmd.accept && (fill_q >= win)) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (cmd.insert) begin
			fill_q <= fill_q + 1'b1;
		end else if (cmd.remove) begin
			fill_q <= fill_q - 1'b1;
			ptr_q  <= ptr_inc;
		end
	end

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the sliding window median filter
// Drives samples through a valid/ready channel with random gaps, applies
// random backpressure on the median channel, and compares every median with
// a predictor that keeps its own arrival ring and sorted window. The window
// size is reprogrammed over APB between runs, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 400000;
	// settle this long once drained
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1000;

	// register map: index 0 is window_size, index 1 holds no register
	localparam logic [swm_pkg::APB_AW-1:0] WS_ADDR  = {swm_pkg::ADDR_IDX_WS, 2'b00};
	localparam logic [swm_pkg::APB_AW-1:0] BAD_ADDR = {~swm_pkg::ADDR_IDX_WS, 2'b00};

	localparam swm_pkg::sample_t S_MAX = 32'sh7FFF_FFFF;
	localparam swm_pkg::sample_t S_MIN = 32'sh8000_0000;

	// windows swept first: saturating, largest, smallest, zero, even, odd
	localparam int WS_SWEEP[10] = '{127, 64, 1, 2, 0, 4, 65, 63, 8, 5};

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [swm_pkg::APB_AW-1:0]   paddr;
	logic [swm_pkg::APB_DW-1:0]   pwdata;
	logic [swm_pkg::APB_DW-1:0]   prdata;
	logic                         pready;

	swm_sample_if samp_ch ();
	swm_median_if med_ch ();

	sliding_window_median_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samp_ch),
		.medians (med_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// ------------------------------------------------------------------
	// Predictor state: its own copy of the window and the register
	// ------------------------------------------------------------------
	logic [swm_pkg::WS_W-1:0] ws_shadow;
	swm_pkg::sample_t         arrivals [swm_pkg::WIN_MAX];
	swm_pkg::sample_t         ordered  [swm_pkg::WIN_MAX];
	int                       oldest_slot;
	int                       held_count;

	swm_pkg::sample_t pending_samples[$];
	swm_pkg::sample_t expected_medians[$];
	swm_pkg::sample_t batch[$];

	int  err_cnt;
	int  samples_sent;
	int  medians_seen;
	int  reg_writes;
	int  cycle_cnt;
	bit  no_idle;  // set for stretches with neither gaps nor stalls

	// Zero acts as a window of one; anything above the maximum saturates.
	function automatic int eff_window(input logic [swm_pkg::WS_W-1:0] ws);
		if (ws == '0)
			return 1;
		if (int'(ws) > swm_pkg::WIN_MAX)
			return swm_pkg::WIN_MAX;
		return int'(ws);
	endfunction

	// Account for one accepted sample; queue a median once the window is full.
	task automatic advance_window(input swm_pkg::sample_t s);
		int               w;
		int               pos;
		swm_pkg::sample_t leaving;
		w = eff_window(ws_shadow);
		if (held_count >= w) begin
			held_count  = 0;
			oldest_slot = 0;
		end
		arrivals[(oldest_slot + held_count) % swm_pkg::WIN_MAX] = s;
		// insert after any equal values
		pos = 0;
		while (pos < held_count && ordered[pos] <= s)
			pos++;
		for (int i = held_count; i > pos; i--)
			ordered[i] = ordered[i-1];
		ordered[pos] = s;
		held_count++;
		if (held_count < w)
			return;
		expected_medians = {expected_medians, ordered[(w - 1) / 2]};
		// evict the oldest by value
		leaving = arrivals[oldest_slot];
		pos = 0;
		while (pos < held_count && ordered[pos] != leaving)
			pos++;
		for (int i = pos; i + 1 < held_count; i++)
			ordered[i] = ordered[i+1];
		held_count--;
		oldest_slot = (oldest_slot + 1) % swm_pkg::WIN_MAX;
	endtask

	// ------------------------------------------------------------------
	// Clock and cycle limit
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d medians outstanding",
				$time, cycle_cnt, expected_medians.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sample driver: present queued samples, hold each until accepted,
	// and idle a random number of cycles before the next one.
	// ------------------------------------------------------------------
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_ch.valid  <= 1'b0;
			samp_ch.sample <= '0;
			gap_left = 0;
		end else begin
			// transaction at this edge: the block has taken the sample
			if (samp_ch.valid && samp_ch.ready) begin
				advance_window(samp_ch.sample);
				samples_sent++;
			end
			// load the next sample only when the slot is free
			if (!samp_ch.valid || samp_ch.ready) begin
				if (gap_left > 0 || pending_samples.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					samp_ch.valid <= 1'b0;
				end else begin
					samp_ch.valid  <= 1'b1;
					samp_ch.sample <= pending_samples.pop_front();
					gap_left = no_idle ? 0 : $urandom_range(0, 8);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Median monitor: check each transaction against the oldest expected
	// median, then stall the next one for a random number of cycles.
	// ------------------------------------------------------------------
	int stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			med_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (med_ch.valid && med_ch.ready) begin
				medians_seen++;
				if (expected_medians.size() == 0) begin
					$display("%0t: unexpected median, expected none, actual %0d",
						$time, med_ch.median);
					err_cnt++;
				end else if (med_ch.median !== expected_medians[0]) begin
					$display("%0t: median mismatch, expected %0d, actual %0d",
						$time, expected_medians[0], med_ch.median);
					err_cnt++;
					void'(expected_medians.pop_front());
				end else begin
					void'(expected_medians.pop_front());
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 8);
			end
			// count the stall down only while a median is waiting
			if (stall_left > 0) begin
				if (med_ch.valid)
					stall_left--;
				med_ch.ready <= 1'b0;
			end else begin
				med_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// APB access tasks
	// ------------------------------------------------------------------
	task automatic reg_write(input logic [swm_pkg::APB_AW-1:0] addr,
		input logic [swm_pkg::APB_DW-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		// the write lands at the edge that completes the access phase
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		reg_writes++;
		// only index 0 holds a register; a write there empties the window
		if (addr == WS_ADDR) begin
			ws_shadow   = data[swm_pkg::WS_W-1:0];
			held_count  = 0;
			oldest_slot = 0;
		end
	endtask

	task automatic reg_check(input logic [swm_pkg::APB_AW-1:0] addr);
		logic [swm_pkg::APB_DW-1:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== swm_pkg::APB_DW'(ws_shadow)) begin
			$display("%0t: window_size readback mismatch, expected %0d, actual %0d",
				$time, ws_shadow, got);
			err_cnt++;
		end
	endtask

	// Program a window size with random bits above the register field.
	task automatic set_window(input int ws);
		reg_write(WS_ADDR, ($urandom & ~32'h7F) | (ws & 32'h7F));
		reg_check(WS_ADDR);
	endtask

	// ------------------------------------------------------------------
	// Flow helpers
	// ------------------------------------------------------------------
	// Wait until every queued sample is taken and every median has come,
	// then let the block finish any sample that produces no median.
	task automatic drain();
		while (pending_samples.size() != 0 || samp_ch.valid || expected_medians.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic play_batch();
		foreach (batch[i])
			pending_samples = {pending_samples, batch[i]};
		batch.delete();
		drain();
	endtask

	// Mostly full-range values, some tight clusters to force equal values,
	// and some extremes.
	function automatic swm_pkg::sample_t rand_sample();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick <= 5)
			return swm_pkg::sample_t'($urandom);
		if (pick <= 8)
			return swm_pkg::sample_t'($urandom_range(0, 6)) - 3;
		case ($urandom_range(0, 3))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return '0;
			default: return -1;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	int random_items;
	int phase_cnt;
	int ws_pick;
	int run_len;

	initial begin
		// known values on every input from time zero
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		samp_ch.valid  = 1'b0;
		samp_ch.sample = '0;
		med_ch.ready   = 1'b0;
		no_idle        = 1'b0;
		err_cnt        = 0;
		samples_sent   = 0;
		medians_seen   = 0;
		reg_writes     = 0;
		cycle_cnt      = 0;
		random_items   = 0;
		phase_cnt      = 0;
		ws_shadow      = swm_pkg::WS_RESET;
		held_count     = 0;
		oldest_slot    = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed: reset window of three ---
		reg_check(WS_ADDR);
		batch = {S_MAX, S_MIN, 32'sd0, -32'sd1, 32'sd1,
			32'sd7, 32'sd7, 32'sd7, -32'sd7, 32'sd7};
		play_batch();

		// a write to an unmapped index must leave the window alone
		reg_write(BAD_ADDR, 32'h0000_0001);
		reg_check(WS_ADDR);
		batch = {32'sd2, 32'sd2, -32'sd2};
		play_batch();

		// window of one passes every sample through
		set_window(1);
		batch = {S_MIN, S_MAX, 32'sh5555_5555, 32'shAAAA_AAAA};
		play_batch();

		// window of zero behaves like a window of one
		set_window(0);
		batch = {-32'sd1, 32'sd0};
		play_batch();

		// even window takes the lower middle element
		set_window(2);
		batch = {32'sd10, -32'sd10, S_MAX, S_MIN};
		play_batch();

		// --- random: sweep the extremes first, then random sizes ---
		while (random_items < RANDOM_ITEMS) begin
			if (phase_cnt < $size(WS_SWEEP))
				ws_pick = WS_SWEEP[phase_cnt];
			else if ($urandom_range(0, 2) == 0)
				ws_pick = $urandom_range(0, 127);
			else
				ws_pick = $urandom_range(1, 12);
			phase_cnt++;
			set_window(ws_pick);
			// some runs go back to back on both sides
			no_idle = ($urandom_range(0, 3) == 0);
			run_len = eff_window(ws_pick[swm_pkg::WS_W-1:0]) + $urandom_range(4, 40);
			for (int i = 0; i < run_len; i++)
				batch = {batch, rand_sample()};
			random_items += run_len;
			play_batch();
		end
		no_idle = 1'b0;

		if (expected_medians.size() != 0) begin
			$display("%0t: %0d expected medians never arrived",
				$time, expected_medians.size());
			err_cnt++;
		end

		$display("Sent %0d samples and checked %0d medians over %0d window runs.",
			samples_sent, medians_seen, phase_cnt + 5);
		$display("Issued %0d register writes; %0d failures found.", reg_writes, err_cnt);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
